>>> sv/sio_pkg.sv
`default_nettype none

package sio_pkg;

    // Fixed geometry of the register file.
    localparam int GLOBAL_REG_COUNT = 48;
    localparam int DEVICE_REG_COUNT = 256;
    localparam int GLB_ADDR_W       = 6;
    localparam int REG_IDX_W        = 8;
    localparam int DEV_NUM_W        = 4;
    localparam int REG_W            = 8;
    localparam int MASK_W           = 6;
    localparam int PADDR_W          = 3;

    // Request codes.
    localparam logic CMD_READ   = 1'b0;
    localparam logic CMD_WRITE  = 1'b1;
    localparam logic PORT_INDEX = 1'b0;
    localparam logic PORT_DATA  = 1'b1;

    // Configuration register index, taken from byte address bit 2.
    localparam logic CFG_IDX_CHIP_VARIANT = 1'b0;

    // Key bytes on the index port.
    localparam logic [7:0] KEY_ENTER = 8'h55;
    localparam logic [7:0] KEY_EXIT  = 8'hAA;

    // Register indexes with special meaning.
    localparam logic [7:0] IDX_DEV_SEL    = 8'h07;
    localparam logic [7:0] IDX_CHIP_ID    = 8'h20;
    localparam logic [7:0] IDX_CHIP_REV   = 8'h21;
    localparam logic [7:0] IDX_GLB_ENABLE = 8'h22;
    localparam logic [7:0] IDX_ACTIVATE   = 8'h30;
    localparam logic [7:0] IDX_BASE_HI    = 8'h60;
    localparam logic [7:0] IDX_BASE_LO    = 8'h61;
    localparam logic [7:0] IDX_IRQ_SEL    = 8'h70;
    localparam logic [3:0] IDX_IRQ_BLOCK  = 4'h7;

    localparam logic [7:0] READ_IDLE = 8'hFF;
    localparam logic [7:0] ID_BASE   = 8'h02;

    // Logical device numbers.
    localparam logic [7:0] DEV_FDC  = 8'd0;
    localparam logic [7:0] DEV_PAR  = 8'd3;
    localparam logic [7:0] DEV_SER1 = 8'd4;
    localparam logic [7:0] DEV_SER2 = 8'd5;
    localparam logic [7:0] DEV_AUX  = 8'd8;
    localparam logic [7:0] DEV_ACB  = 8'd9;
    localparam logic [7:0] DEV_IRQ_FIRST_FREE = 8'd4;

    // Decode change flags.
    localparam logic [MASK_W-1:0] MASK_FDC  = 6'b000001;
    localparam logic [MASK_W-1:0] MASK_PAR  = 6'b000010;
    localparam logic [MASK_W-1:0] MASK_SER1 = 6'b000100;
    localparam logic [MASK_W-1:0] MASK_SER2 = 6'b001000;
    localparam logic [MASK_W-1:0] MASK_AUX  = 6'b010000;
    localparam logic [MASK_W-1:0] MASK_ACB  = 6'b100000;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // One write into the global register memory.
    typedef struct packed {
        logic                  we;
        logic [GLB_ADDR_W-1:0] addr;
        logic [REG_W-1:0]      data;
    } glb_wr_t;

    // Power-on value of a global register. The chip id entry is overridden on read.
    function automatic logic [REG_W-1:0] glb_default(input logic [GLB_ADDR_W-1:0] idx);
        logic [REG_W-1:0] val;
        unique case (idx)
            6'h03:   val = 8'h03;
            6'h21:   val = 8'h01;
            6'h22:   val = 8'h39;
            6'h24:   val = 8'h04;
            6'h26:   val = 8'hF0;
            6'h27:   val = 8'h03;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    // Power-on value of a logical device register.
    function automatic logic [REG_W-1:0] dev_default(input logic [DEV_NUM_W-1:0] dev,
                                                     input logic [REG_IDX_W-1:0] idx);
        logic [REG_W-1:0] val;
        unique case ({dev, idx})
            12'h030: val = 8'h01;
            12'h060: val = 8'h03;
            12'h061: val = 8'hF0;
            12'h070: val = 8'h06;
            12'h074: val = 8'h02;
            12'h0F0: val = 8'h0E;
            12'h0F2: val = 8'hFF;
            12'h160: val = 8'h01;
            12'h161: val = 8'hF0;
            12'h162: val = 8'h03;
            12'h163: val = 8'hF6;
            12'h170: val = 8'h0E;
            12'h1F0: val = 8'h0C;
            12'h260: val = 8'h01;
            12'h261: val = 8'h70;
            12'h262: val = 8'h03;
            12'h263: val = 8'h76;
            12'h270: val = 8'h0F;
            12'h330: val = 8'h01;
            12'h360: val = 8'h03;
            12'h361: val = 8'h78;
            12'h370: val = 8'h07;
            12'h374: val = 8'h04;
            12'h3F0: val = 8'h3C;
            12'h430: val = 8'h01;
            12'h460: val = 8'h03;
            12'h461: val = 8'hF8;
            12'h470: val = 8'h04;
            12'h4F0: val = 8'h03;
            12'h530: val = 8'h01;
            12'h560: val = 8'h02;
            12'h561: val = 8'hF8;
            12'h570: val = 8'h03;
            12'h574: val = 8'h04;
            12'h5F1: val = 8'h02;
            12'h5F2: val = 8'h03;
            12'h663: val = 8'h70;
            12'h6F4: val = 8'h03;
            12'h730: val = 8'h01;
            12'h761: val = 8'h60;
            12'h770: val = 8'h01;
            12'h830: val = 8'h01;
            12'h861: val = 8'hEA;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

>>> sv/sio_ram.sv
`default_nettype none

module sio_ram
    import sio_pkg::*;
#(
    parameter int DEPTH  = 48,
    parameter int ADDR_W = 6
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [REG_W-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [REG_W-1:0]  rdata
);

    logic [REG_W-1:0] mem [DEPTH];
    logic [REG_W-1:0] rdata_reg;

    // Single write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> sv/sio_init.sv
`default_nettype none

module sio_init
    import sio_pkg::*;
#(
    parameter int DEVICE_COUNT = 10
) (
    input  wire logic                                            aclk,
    input  wire logic                                            aresetn,
    output logic                                                 busy,
    output logic                                                 dev_we,
    output logic [$clog2(DEVICE_COUNT)+REG_IDX_W-1:0]            dev_waddr,
    output logic [REG_W-1:0]                                     dev_wdata,
    output glb_wr_t                                              glb_wr
);

    localparam int DEV_W  = $clog2(DEVICE_COUNT);
    localparam int ADDR_W = DEV_W + REG_IDX_W;
    localparam int DEPTH  = DEVICE_COUNT * DEVICE_REG_COUNT;

    logic              busy_reg;
    logic              busy_next;
    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] cnt_next;

    // Sweep every device entry once after reset; the global entries ride along.
    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (busy_reg) begin
            cnt_next = cnt_reg + ADDR_W'(1);
            if (cnt_reg == ADDR_W'(DEPTH - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign busy      = busy_reg;
    assign dev_we    = busy_reg;
    assign dev_waddr = cnt_reg;
    assign dev_wdata = dev_default(DEV_NUM_W'(cnt_reg[ADDR_W-1:REG_IDX_W]),
                                   cnt_reg[REG_IDX_W-1:0]);

    // Global registers take the first part of the sweep.
    always_comb begin
        glb_wr.we   = busy_reg && (cnt_reg < ADDR_W'(GLOBAL_REG_COUNT));
        glb_wr.addr = cnt_reg[GLB_ADDR_W-1:0];
        glb_wr.data = glb_default(cnt_reg[GLB_ADDR_W-1:0]);
    end

endmodule

`default_nettype wire

>>> sv/superio_config_register_file.sv
// Index/data configuration port of a Super I/O device.
// Requests arrive on the s_ channel (s_cmd, s_port_sel, s_wdata) with valid and
// ready; every request gives exactly one result on the m_ channel (m_rdata,
// m_reconfig_mask). Writing 0x55 twice to the index port enters configuration
// mode and 0xAA leaves it; in that mode the data port reaches the 48 global
// registers or the registers of the logical device selected by global index 7.
// A request is handled as the memory read in the accepting cycle, then the
// modify and write-back cycle that loads the output register. A new request is
// accepted only once the previous one has finished its write-back; the read
// port of each register memory is registered.
// The output register lets a new request be accepted while a result waits; if
// the receiver stalls, the following request holds in its write-back cycle
// until the output register is free.
// After reset a clearing pass loads the power-on values with s_ready low; the
// APB port is served throughout.
// The APB port holds chip_variant (0: id 2, 1: id 3) at byte address 0.
`default_nettype none

module superio_config_register_file
    import sio_pkg::*;
#(
    parameter int DEVICE_COUNT = 10
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // request channel
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_cmd,
    input  wire logic               s_port_sel,
    input  wire logic [7:0]         s_wdata,
    // result channel
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [7:0]         m_rdata,
    output logic      [MASK_W-1:0]  m_reconfig_mask,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    localparam int DEV_W     = $clog2(DEVICE_COUNT);
    localparam int DEV_ADDR_W = DEV_W + REG_IDX_W;
    localparam int DEV_DEPTH = DEVICE_COUNT * DEVICE_REG_COUNT;

    state_t state_reg, state_next;

    logic              cfg_mode_reg,  cfg_mode_next;
    logic              key_seen_reg,  key_seen_next;
    logic [7:0]        reg_index_reg, reg_index_next;
    logic [7:0]        dev_sel_reg,   dev_sel_next;
    logic              variant_reg;
    logic              m_valid_reg,   m_valid_next;
    logic [7:0]        m_rdata_reg,   m_rdata_next;
    logic [MASK_W-1:0] m_mask_reg,    m_mask_next;

    logic              item_cmd_reg;
    logic              item_port_reg;
    logic [7:0]        item_wdata_reg;

    logic              accept;
    logic              can_finish;
    logic              finish;
    logic              cfg_wr;

    logic              init_busy;
    logic              init_dev_we;
    logic [DEV_ADDR_W-1:0] init_dev_waddr;
    logic [REG_W-1:0]  init_dev_wdata;
    glb_wr_t           init_glb_wr;
    glb_wr_t           glb_wr;

    logic [REG_W-1:0]  glb_rdata;
    logic [REG_W-1:0]  dev_rdata;
    logic [DEV_ADDR_W-1:0] dev_addr;
    logic              dev_we;
    logic [DEV_ADDR_W-1:0] dev_waddr;
    logic [REG_W-1:0]  dev_wdata;

    logic [7:0]        op_rdata;
    logic [MASK_W-1:0] op_mask;
    logic              op_glb_we;
    logic              op_dev_we;
    logic              is_glb;
    logic              dev_present;
    logic [7:0]        glb_view;
    logic [7:0]        glb_diff;
    logic [7:0]        dev_diff;
    logic [MASK_W-1:0] dev_bit;
    logic              uses_irq;
    logic              dev_ok;
    logic              decode_idx;

    // Clearing pass after reset.
    sio_init #(
        .DEVICE_COUNT(DEVICE_COUNT)
    ) u_init (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .busy      (init_busy),
        .dev_we    (init_dev_we),
        .dev_waddr (init_dev_waddr),
        .dev_wdata (init_dev_wdata),
        .glb_wr    (init_glb_wr)
    );

    // Register memories; both are read at the accept edge.
    assign dev_addr = {dev_sel_reg[DEV_W-1:0], reg_index_reg};

    sio_ram #(
        .DEPTH  (GLOBAL_REG_COUNT),
        .ADDR_W (GLB_ADDR_W)
    ) u_glb_ram (
        .aclk  (aclk),
        .we    (glb_wr.we),
        .waddr (glb_wr.addr),
        .wdata (glb_wr.data),
        .re    (accept),
        .raddr (reg_index_reg[GLB_ADDR_W-1:0]),
        .rdata (glb_rdata)
    );

    sio_ram #(
        .DEPTH  (DEV_DEPTH),
        .ADDR_W (DEV_ADDR_W)
    ) u_dev_ram (
        .aclk  (aclk),
        .we    (dev_we),
        .waddr (dev_waddr),
        .wdata (dev_wdata),
        .re    (accept),
        .raddr (dev_addr),
        .rdata (dev_rdata)
    );

    // Write port selection: the clearing pass owns the memories while it runs.
    always_comb begin
        if (init_busy) begin
            glb_wr    = init_glb_wr;
            dev_we    = init_dev_we;
            dev_waddr = init_dev_waddr;
            dev_wdata = init_dev_wdata;
        end else begin
            glb_wr.we   = finish && op_glb_we;
            glb_wr.addr = reg_index_reg[GLB_ADDR_W-1:0];
            glb_wr.data = item_wdata_reg;
            dev_we      = finish && op_dev_we;
            dev_waddr   = dev_addr;
            dev_wdata   = item_wdata_reg;
        end
    end

    // Handshakes.
    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign can_finish = !m_valid_reg || m_ready;
    assign finish     = (state_reg == ST_EXEC) && can_finish;
    assign m_valid    = m_valid_reg;
    assign m_rdata    = m_rdata_reg;
    assign m_reconfig_mask = m_mask_reg;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == CFG_IDX_CHIP_VARIANT);
    assign prdata = (paddr[2] == CFG_IDX_CHIP_VARIANT) ? {31'b0, variant_reg} : 32'b0;

    // Per-device write filter and decode flag.
    always_comb begin
        dev_bit  = '0;
        uses_irq = 1'b0;
        dev_ok   = 1'b0;
        unique case (dev_sel_reg)
            DEV_FDC:  begin dev_bit = MASK_FDC;  dev_ok = 1'b1; end
            DEV_PAR:  begin dev_bit = MASK_PAR;  dev_ok = 1'b1; end
            DEV_SER1: begin dev_bit = MASK_SER1; dev_ok = 1'b1; uses_irq = 1'b1; end
            DEV_SER2: begin dev_bit = MASK_SER2; dev_ok = 1'b1; uses_irq = 1'b1; end
            DEV_AUX:  begin dev_bit = MASK_AUX;  dev_ok = 1'b1; uses_irq = 1'b1; end
            DEV_ACB:  begin dev_bit = MASK_ACB;  dev_ok = variant_reg; uses_irq = 1'b1; end
            default:  begin dev_bit = '0; end
        endcase
        // The interrupt block is read-only below the first serial device.
        if ((reg_index_reg[7:4] == IDX_IRQ_BLOCK) && (dev_sel_reg < DEV_IRQ_FIRST_FREE)) begin
            dev_ok = 1'b0;
        end
        if (!dev_present) begin
            dev_ok = 1'b0;
        end
    end

    assign is_glb      = reg_index_reg < 8'(GLOBAL_REG_COUNT);
    assign dev_present = dev_sel_reg < 8'(DEVICE_COUNT);
    assign glb_view    = (reg_index_reg == IDX_CHIP_ID) ? (ID_BASE | {7'b0, variant_reg})
                                                        : glb_rdata;
    assign glb_diff    = item_wdata_reg ^ glb_rdata;
    assign dev_diff    = item_wdata_reg ^ dev_rdata;
    assign decode_idx  = (reg_index_reg == IDX_ACTIVATE) || (reg_index_reg == IDX_BASE_HI)
                      || (reg_index_reg == IDX_BASE_LO)
                      || (uses_irq && (reg_index_reg == IDX_IRQ_SEL));

    // Request decode: result value, memory writes and port state updates.
    always_comb begin
        op_rdata       = '0;
        op_mask        = '0;
        op_glb_we      = 1'b0;
        op_dev_we      = 1'b0;
        cfg_mode_next  = cfg_mode_reg;
        key_seen_next  = key_seen_reg;
        reg_index_next = reg_index_reg;
        dev_sel_next   = dev_sel_reg;
        if (item_cmd_reg == CMD_WRITE) begin
            if (item_port_reg == PORT_INDEX) begin
                if ((item_wdata_reg == KEY_ENTER) && !cfg_mode_reg) begin
                    if (key_seen_reg) begin
                        cfg_mode_next = 1'b1;
                        key_seen_next = 1'b0;
                    end else begin
                        key_seen_next = 1'b1;
                    end
                end else if (cfg_mode_reg) begin
                    if (item_wdata_reg == KEY_EXIT) begin
                        cfg_mode_next = 1'b0;
                    end else begin
                        reg_index_next = item_wdata_reg;
                    end
                end else begin
                    key_seen_next = 1'b0;
                end
            end else if (cfg_mode_reg) begin
                if (is_glb) begin
                    // Identification registers are read-only.
                    if ((reg_index_reg != IDX_CHIP_ID) && (reg_index_reg != IDX_CHIP_REV)) begin
                        op_glb_we = 1'b1;
                        if (reg_index_reg == IDX_DEV_SEL) begin
                            dev_sel_next = item_wdata_reg;
                        end
                        if (reg_index_reg == IDX_GLB_ENABLE) begin
                            op_mask = {2'b00, glb_diff[5], glb_diff[4], glb_diff[3], glb_diff[0]};
                        end
                    end
                end else if (dev_ok) begin
                    op_dev_we = 1'b1;
                    if ((dev_diff != 8'h00) && decode_idx) begin
                        op_mask = dev_bit;
                    end
                end
            end
        end else begin
            if (!cfg_mode_reg) begin
                op_rdata = READ_IDLE;
            end else if (item_port_reg == PORT_INDEX) begin
                op_rdata = reg_index_reg;
            end else if (is_glb) begin
                op_rdata = glb_view;
            end else if (dev_present) begin
                op_rdata = dev_rdata;
            end else begin
                op_rdata = READ_IDLE;
            end
        end
    end

    // Sequencer: clearing pass, wait for a request, then read-modify-write.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_rdata_next = m_rdata_reg;
        m_mask_next  = m_mask_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (!init_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (can_finish) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    m_rdata_next = op_rdata;
                    m_mask_next  = op_mask;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_INIT;
            cfg_mode_reg  <= 1'b0;
            key_seen_reg  <= 1'b0;
            reg_index_reg <= '0;
            dev_sel_reg   <= '0;
            variant_reg   <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (finish) begin
                cfg_mode_reg  <= cfg_mode_next;
                key_seen_reg  <= key_seen_next;
                reg_index_reg <= reg_index_next;
                dev_sel_reg   <= dev_sel_next;
            end
            if (cfg_wr) begin
                variant_reg <= pwdata[0];
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_cmd_reg   <= s_cmd;
            item_port_reg  <= s_port_sel;
            item_wdata_reg <= s_wdata;
        end
        m_rdata_reg <= m_rdata_next;
        m_mask_reg  <= m_mask_next;
    end

endmodule

`default_nettype wire
